>>> src/bitmap_page_frame_allocator_core_assert.svh
// assertion macros for the page frame allocator checker
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BPFA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpfa assertion failed");

// next-cycle implication, checked outside reset
`define BPFA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bpfa assertion failed");

`endif

>>> src/bpfa_pkg.sv
// shared constants and types of the page frame allocator
package bpfa_pkg;

	localparam int ADDR_W     = 24;
	localparam int CNT_W      = 13;
	localparam int OP_W       = 2;
	localparam int ST_W       = 2;

	localparam int NUM_PAGES  = 4096;
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

	localparam int WORD_BITS  = 64;
	localparam int BIT_W      = 6;
	localparam int MAP_WORDS  = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PG_W       = WORD_W + BIT_W;
	localparam int LIM_W      = ($clog2(NUM_PAGES + 1) > CNT_W) ? $clog2(NUM_PAGES + 1) : CNT_W;
	localparam int PIDX_W     = ADDR_W - PAGE_SHIFT;
	localparam int IDX_W      = (PIDX_W > LIM_W) ? PIDX_W : LIM_W;

	localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(4096);

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

	localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
	localparam logic [ST_W-1:0] ST_NO_FREE = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

	typedef struct packed {
		logic            load;
		logic            scan_rd;
		logic            page_rd;
		logic            alloc_wr;
		logic            page_wr;
		logic            finish;
		logic [ST_W-1:0] status;
		logic            addr_sel;
	} ctl_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            limit_zero;
		logic            in_range;
		logic            found;
		logic            exhausted;
	} dp_stat_t;

endpackage

>>> src/bpfa_ctrl.sv
// controller state machine of the page frame allocator
module bpfa_ctrl
	import bpfa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd,
	output logic     busy
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DECIDE  = 3'd1;
	localparam logic [2:0] S_SCAN    = 3'd2;
	localparam logic [2:0] S_PAGE_RD = 3'd3;
	localparam logic [2:0] S_PAGE_WR = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.status = ST_DONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (stat.op)
					OP_ALLOC: begin
						if (stat.limit_zero) begin
							cmd.finish = 1'b1;
							cmd.status = ST_NO_FREE;
							state_d    = S_IDLE;
						end else begin
							state_d = S_SCAN;
						end
					end
					OP_FREE, OP_RESERVE: begin
						if (!stat.in_range) begin
							cmd.finish = 1'b1;
							cmd.status = ST_RANGE;
							state_d    = S_IDLE;
						end else begin
							state_d = S_PAGE_RD;
						end
					end
					default: begin
						// unused op code answers done and touches nothing
						cmd.finish = 1'b1;
						cmd.status = ST_DONE;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				if (stat.found) begin
					cmd.alloc_wr = 1'b1;
					cmd.finish   = 1'b1;
					cmd.status   = ST_DONE;
					cmd.addr_sel = 1'b1;
					state_d      = S_IDLE;
				end else if (stat.exhausted) begin
					cmd.finish = 1'b1;
					cmd.status = ST_NO_FREE;
					state_d    = S_IDLE;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			S_PAGE_RD: begin
				cmd.page_rd = 1'b1;
				state_d     = S_PAGE_WR;
			end
			S_PAGE_WR: begin
				cmd.page_wr = 1'b1;
				cmd.finish  = 1'b1;
				cmd.status  = ST_DONE;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> src/bpfa_datapath.sv
// used-page map memory, scan logic and result registers
module bpfa_datapath
	import bpfa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic [OP_W-1:0]   op,
	input  logic [ADDR_W-1:0] frame_address,
	input  ctl_cmd_t          cmd,
	output dp_stat_t          stat,
	output logic              done,
	output logic [ST_W-1:0]   status,
	output logic [ADDR_W-1:0] alloc_address
);

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] vld_q;

	logic [CNT_W-1:0]     page_count_q;
	logic [OP_W-1:0]      op_q;
	logic [IDX_W-1:0]     page_q;
	logic [LIM_W-1:0]     limit_q;
	logic [WORD_W-1:0]    wcnt_q;

	logic [WORD_BITS-1:0] rdata_s1;
	logic                 rvld_s1;
	logic [WORD_W-1:0]    chk_idx_s1;
	logic                 chk_vld_s1;

	logic                 done_q;
	logic [ST_W-1:0]      status_q;
	logic [ADDR_W-1:0]    addr_q;

	logic [LIM_W-1:0]     limit_now;
	logic [LIM_W-1:0]     lim_m1;
	logic [WORD_W-1:0]    last_word;
	logic [BIT_W-1:0]     rem_bits;
	logic [WORD_BITS-1:0] cur_word;
	logic [WORD_BITS-1:0] range_mask;
	logic [WORD_BITS-1:0] avail;
	logic [BIT_W-1:0]     fbit;
	logic                 found;
	logic [PG_W-1:0]      found_page;
	logic [ADDR_W+PG_W-1:0] found_prod;
	logic [WORD_W-1:0]    page_word;
	logic [BIT_W-1:0]     page_bit;
	logic [WORD_BITS-1:0] page_new;
	logic [WORD_W-1:0]    rd_addr;
	logic                 wr_en;
	logic [WORD_W-1:0]    wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	// active count is the register clamped to the map capacity
	assign limit_now = (LIM_W'(page_count_q) > LIM_W'(NUM_PAGES)) ?
		LIM_W'(NUM_PAGES) : LIM_W'(page_count_q);

	assign lim_m1    = limit_q - LIM_W'(1);
	assign last_word = lim_m1[PG_W-1:BIT_W];
	assign rem_bits  = limit_q[BIT_W-1:0];

	// never-written words read as all used
	assign cur_word = rvld_s1 ? rdata_s1 : '1;

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			range_mask[b] = (chk_idx_s1 != last_word) || (rem_bits == '0) ||
				(BIT_W'(b) < rem_bits);
		end
	end

	assign avail = ~cur_word & range_mask;
	assign found = chk_vld_s1 && (avail != '0);

	// lowest free bit of the checked word
	always_comb begin
		fbit = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (avail[b]) begin
				fbit = BIT_W'(b);
			end
		end
	end

	assign found_page = {chk_idx_s1, fbit};
	assign found_prod = (ADDR_W + PG_W)'(found_page) << PAGE_SHIFT;

	assign page_word = page_q[PG_W-1:BIT_W];
	assign page_bit  = page_q[BIT_W-1:0];

	always_comb begin
		page_new = cur_word;
		page_new[page_bit] = (op_q == OP_RESERVE);
	end

	assign rd_addr = cmd.page_rd ? page_word : wcnt_q;

	always_comb begin
		wr_en   = cmd.alloc_wr || cmd.page_wr;
		wr_addr = cmd.alloc_wr ? chk_idx_s1 : page_word;
		wr_data = cur_word;
		if (cmd.alloc_wr) begin
			wr_data[fbit] = 1'b1;
		end else begin
			wr_data = page_new;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1   <= mem[rd_addr];
		chk_idx_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rvld_s1    <= 1'b0;
			chk_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rvld_s1    <= vld_q[rd_addr];
			chk_vld_s1 <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q <= RESET_COUNT;
		end else if (cfg_we) begin
			page_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			page_q  <= IDX_W'(frame_address[ADDR_W-1:PAGE_SHIFT]);
			limit_q <= limit_now;
		end
	end

	// scan counter holds at the last word of the active range
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wcnt_q <= '0;
		end else if (cmd.scan_rd && (wcnt_q != last_word)) begin
			wcnt_q <= wcnt_q + WORD_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= cmd.status;
			addr_q   <= cmd.addr_sel ? found_prod[ADDR_W-1:0] : '0;
		end
	end

	assign stat.op         = op_q;
	assign stat.limit_zero = (limit_q == '0);
	assign stat.in_range   = (page_q < IDX_W'(limit_q));
	assign stat.found      = found;
	assign stat.exhausted  = chk_vld_s1 && !found && (chk_idx_s1 == last_word);

	assign done          = done_q;
	assign status        = status_q;
	assign alloc_address = addr_q;

endmodule

>>> src/bitmap_page_frame_allocator_core.sv
// Bitmap page frame allocator: one used/free bit per page, all pages used after reset.
// A request is taken when start is high and busy is low; its one result word appears on
// status and alloc_address for exactly one cycle with done high, and must be taken then,
// since the receiver cannot hold it off. Free and reserve step through the decide, page
// read and page write states, and done is registered after the last. Allocate reads one
// 64-page map word per cycle from the map memory and stops at the first word with a free
// page or after the last word of the active range; a zero count, an out-of-range page or the
// unused op code is answered from the decide state. busy falls in the cycle done is shown,
// so the next request may start then. The user must write the page count register through
// cfg_we and cfg_wdata only while the block is idle; the block does not enforce this.
module bitmap_page_frame_allocator_core
	import bpfa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic              start,
	output logic              busy,
	input  logic [OP_W-1:0]   op,
	input  logic [ADDR_W-1:0] frame_address,
	output logic              done,
	output logic [ST_W-1:0]   status,
	output logic [ADDR_W-1:0] alloc_address
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	bpfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	bpfa_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.op            (op),
		.frame_address (frame_address),
		.cmd           (cmd),
		.stat          (stat),
		.done          (done),
		.status        (status),
		.alloc_address (alloc_address)
	);

endmodule

>>> src/bpfa_checker.sv
// port-level checker of the page frame allocator and its bind
`include "bitmap_page_frame_allocator_core_assert.svh"

module bpfa_checker
	import bpfa_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [ST_W-1:0]   status,
	input logic [ADDR_W-1:0] alloc_address
);

	`BPFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`BPFA_ASSERT_NEXT(a_done_pulse, done, !done)
	`BPFA_ASSERT_NOW(a_done_idle, done, !busy)
	`BPFA_ASSERT_NOW(a_status_code, done, status == ST_DONE || status == ST_NO_FREE || status == ST_RANGE)
	`BPFA_ASSERT_NOW(a_fail_addr_zero, done && status != ST_DONE, alloc_address == '0)

endmodule

bind bitmap_page_frame_allocator_core bpfa_checker u_bpfa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.alloc_address (alloc_address)
);
